// File: hw/rtl/info_frame_deframer_rx_unit_assert.svh
// assertion macros shared by the deframer front end and queue
// each macro expects clk and rst_n in the scope where it is used
`ifndef INFO_FRAME_DEFRAMER_RX_UNIT_ASSERT_SVH
`define INFO_FRAME_DEFRAMER_RX_UNIT_ASSERT_SVH

`ifndef SYNTH

// condition holds at every clock edge out of reset
`define IFDR_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deframer assertion failed");

// consequent holds in the same cycle as the antecedent
`define IFDR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// consequent holds in the cycle after the antecedent
`define IFDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`else

`define IFDR_ASSERT_ALWAYS(label, cond)
`define IFDR_ASSERT_IMPL(label, ante, cons)
`define IFDR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/ifdr_pkg.sv
`default_nettype none

package ifdr_pkg;

    localparam int LEN_W = 11;
    localparam int BYTE_W = 8;
    localparam int STATUS_W = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int MAX_FRAME_BYTES_DEF = 1024;
    localparam int LEN_CAP = 2045;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd1024;

    localparam int QUEUE_DEPTH = 2;

    // register index, taken from paddr word bits
    localparam logic REG_MAX_PAYLOAD_LEN = 1'b0;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h5c;
    localparam logic [BYTE_W-1:0] ADDR_MAIN = 8'h03;
    localparam logic [BYTE_W-1:0] ADDR_ALT  = 8'h01;
    localparam logic [BYTE_W-1:0] CTRL_SEQ0 = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_SEQ1 = 8'h02;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h5d;
    localparam logic [BYTE_W-1:0] ESC_FLAG  = 8'h7c;
    localparam logic [BYTE_W-1:0] ESC_SELF  = 8'h7d;

    localparam logic [STATUS_W-1:0] STAT_PAYLOAD  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_GOOD     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BCC_ERR  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 2'd3;

    typedef enum logic [4:0] {
        S_HUNT = 5'b00001,
        S_FLAG = 5'b00010,
        S_ADDR = 5'b00100,
        S_CTRL = 5'b01000,
        S_DATA = 5'b10000
    } frame_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic                frame_done;
        logic [STATUS_W-1:0] frame_status;
        logic                frame_seq;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/ifdr_front.sv
`default_nettype none

`include "info_frame_deframer_rx_unit_assert.svh"

module ifdr_front
    import ifdr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [LEN_W-1:0] max_len,
    output logic                  push,
    output result_t               res
);

    localparam int CAP = (MAX_FRAME_BYTES < LEN_CAP) ? MAX_FRAME_BYTES : LEN_CAP;
    localparam logic [LEN_W-1:0] CAP_W = LEN_W'(CAP);

    frame_state_t      state_reg, state_next;
    logic              expected_seq_reg, expected_seq_next;
    logic              escape_pending_reg, escape_pending_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] running_xor_reg, running_xor_next;
    logic [LEN_W-1:0]  payload_count_reg, payload_count_next;
    logic [BYTE_W-1:0] control_seen_reg, control_seen_next;

    logic [LEN_W-1:0]  lim;
    logic [LEN_W:0]    lim_w;
    logic [LEN_W:0]    lim_p1;
    logic [LEN_W:0]    cnt_w;
    logic [BYTE_W-1:0] ctrl_expect;

    assign lim         = (max_len > CAP_W) ? CAP_W : max_len;
    assign lim_w       = {1'b0, lim};
    assign lim_p1      = lim_w + (LEN_W+1)'(1);
    assign cnt_w       = {1'b0, payload_count_reg};
    assign ctrl_expect = expected_seq_reg ? CTRL_SEQ1 : CTRL_SEQ0;

    always_comb
    begin
        state_next          = state_reg;
        expected_seq_next   = expected_seq_reg;
        escape_pending_next = escape_pending_reg;
        held_byte_next      = held_byte_reg;
        held_valid_next     = held_valid_reg;
        running_xor_next    = running_xor_reg;
        payload_count_next  = payload_count_reg;
        control_seen_next   = control_seen_reg;
        push                = 1'b0;
        res                 = '0;
        res.frame_seq       = expected_seq_reg;

        if (accept)
        begin
            unique case (state_reg)
                S_HUNT:
                begin
                    if (rx_byte == FLAG_BYTE)
                        state_next = S_FLAG;
                end
                S_FLAG:
                begin
                    if (rx_byte == FLAG_BYTE)
                        state_next = S_FLAG;
                    else if (rx_byte == ADDR_MAIN || rx_byte == ADDR_ALT)
                    begin
                        running_xor_next = rx_byte;
                        state_next       = S_ADDR;
                    end
                    else
                        state_next = S_HUNT;
                end
                S_ADDR:
                begin
                    if (rx_byte == FLAG_BYTE)
                        state_next = S_FLAG;
                    else if (rx_byte == ctrl_expect)
                    begin
                        control_seen_next = rx_byte;
                        state_next        = S_CTRL;
                    end
                    else
                        state_next = S_HUNT;
                end
                S_CTRL:
                begin
                    if (rx_byte == FLAG_BYTE)
                        state_next = S_FLAG;
                    else if (rx_byte == (running_xor_reg ^ control_seen_reg))
                    begin
                        escape_pending_next = 1'b0;
                        held_byte_next      = '0;
                        held_valid_next     = 1'b0;
                        running_xor_next    = '0;
                        payload_count_next  = '0;
                        state_next          = S_DATA;
                    end
                    else
                        state_next = S_HUNT;
                end
                S_DATA:
                begin
                    if (rx_byte == FLAG_BYTE)
                    begin
                        // closing flag: status, then treat it as the next opening flag
                        push           = 1'b1;
                        res.frame_done = 1'b1;
                        if (cnt_w > lim_p1)
                            res.frame_status = STAT_TOO_LONG;
                        else if (held_valid_reg && held_byte_reg == running_xor_reg)
                            res.frame_status = STAT_GOOD;
                        else
                            res.frame_status = STAT_BCC_ERR;
                        if (res.frame_status == STAT_GOOD)
                            expected_seq_next = ~expected_seq_reg;
                        escape_pending_next = 1'b0;
                        held_byte_next      = '0;
                        held_valid_next     = 1'b0;
                        running_xor_next    = '0;
                        payload_count_next  = '0;
                        state_next          = S_FLAG;
                    end
                    else if (escape_pending_reg && rx_byte == ESC_FLAG)
                    begin
                        held_byte_next      = FLAG_BYTE;
                        escape_pending_next = 1'b0;
                    end
                    else if (escape_pending_reg && rx_byte == ESC_SELF)
                        escape_pending_next = 1'b0;
                    else
                    begin
                        // release the held byte, hold the new one
                        if (held_valid_reg && cnt_w <= lim_w)
                        begin
                            push             = 1'b1;
                            res.data_byte    = held_byte_reg;
                            res.frame_status = STAT_PAYLOAD;
                            running_xor_next = running_xor_reg ^ held_byte_reg;
                        end
                        held_byte_next  = rx_byte;
                        held_valid_next = 1'b1;
                        if (cnt_w <= lim_p1)
                            payload_count_next = payload_count_reg + LEN_W'(1);
                        escape_pending_next = (rx_byte == ESC_BYTE);
                    end
                end
                default:
                    state_next = S_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_HUNT;
            expected_seq_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
            held_byte_reg      <= '0;
            held_valid_reg     <= 1'b0;
            running_xor_reg    <= '0;
            payload_count_reg  <= '0;
            control_seen_reg   <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            expected_seq_reg   <= expected_seq_next;
            escape_pending_reg <= escape_pending_next;
            held_byte_reg      <= held_byte_next;
            held_valid_reg     <= held_valid_next;
            running_xor_reg    <= running_xor_next;
            payload_count_reg  <= payload_count_next;
            control_seen_reg   <= control_seen_next;
        end
    end

    `IFDR_ASSERT_IMPL(a_push_only_in_data, push, state_reg == S_DATA)
    `IFDR_ASSERT_NEXT(a_good_toggles_seq, push && res.frame_status == STAT_GOOD && res.frame_done, expected_seq_reg != $past(expected_seq_reg))

endmodule

`default_nettype wire

// File: hw/rtl/ifdr_queue.sv
`default_nettype none

`include "info_frame_deframer_rx_unit_assert.svh"

module ifdr_queue
    import ifdr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output logic         full,
    output logic         nonempty,
    output result_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    result_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `IFDR_ASSERT_IMPL(a_no_push_when_full, push, !full)
    `IFDR_ASSERT_IMPL(a_no_pop_when_empty, pop, nonempty)
    `IFDR_ASSERT_ALWAYS(a_count_in_range, count_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// File: hw/rtl/ifdr_back.sv
`default_nettype none

module ifdr_back
    import ifdr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_nonempty,
    input  wire result_t   q_head,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output logic [BYTE_W-1:0]   data_byte,
    output logic                frame_done,
    output logic [STATUS_W-1:0] frame_status,
    output logic                frame_seq
);

    logic    valid_reg;
    result_t res_reg;

    // refill the output register when it is empty or being taken
    assign pop = q_nonempty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= q_nonempty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= q_head;
    end

    assign out_valid    = valid_reg;
    assign data_byte    = res_reg.data_byte;
    assign frame_done   = res_reg.frame_done;
    assign frame_status = res_reg.frame_status;
    assign frame_seq    = res_reg.frame_seq;

endmodule

`default_nettype wire

// File: hw/rtl/info_frame_deframer_rx_unit.sv
`default_nettype none

// receiver for byte-stuffed information frames with an xor block check.
// one raw byte is accepted per cycle with no bubbles; the only cause of
// in_stall is a full two-entry result queue, which builds up only while the
// consumer holds out_stall. a result passes through the queue and the output
// register on its way out. the header (flag 0x5c, address 0x03 or 0x01,
// control 0x00/0x02 per the expected sequence bit, bcc1) is checked in the
// front end; bad headers drop the frame silently. payload bytes come out
// destuffed and one byte late, so bcc2 is never delivered; the closing flag
// gives one status result (good, bcc2 error, too long) and also opens the
// next frame. max_payload_len at byte address 0 caps the payload length,
// further clamped to MAX_FRAME_BYTES and 2045; write it only while idle.

module info_frame_deframer_rx_unit
    import ifdr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // byte input
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [BYTE_W-1:0]   rx_byte,
    // result output
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [BYTE_W-1:0]        data_byte,
    output logic                     frame_done,
    output logic [STATUS_W-1:0]      frame_status,
    output logic                     frame_seq,
    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    logic [LEN_W-1:0] max_len_reg;
    logic             reg_hit;
    logic             accept;
    logic             q_full;
    logic             q_nonempty;
    logic             q_pop;
    logic             f_push;
    result_t          f_res;
    result_t          q_head;

    // register port: zero wait states, one register at word index 0
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_MAX_PAYLOAD_LEN);
    assign prdata  = reg_hit ? {{(PDATA_W-LEN_W){1'b0}}, max_len_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (psel && penable && pwrite && pready && reg_hit)
            max_len_reg <= pwdata[LEN_W-1:0];
    end

    // input side stalls only on a full queue
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // front end: header check, destuffing, block check, status
    ifdr_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .max_len (max_len_reg),
        .push    (f_push),
        .res     (f_res)
    );

    // short queue decoupling the two sides
    ifdr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (f_res),
        .pop       (q_pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    // back end: output register toward the consumer
    ifdr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_nonempty),
        .q_head       (q_head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .frame_done   (frame_done),
        .frame_status (frame_status),
        .frame_seq    (frame_seq)
    );

endmodule

`default_nettype wire
